FILE: rtl/locked_eeprom_access_gate_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the locked byte store
// Shared concurrent check macros; empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef LOCKED_EEPROM_ACCESS_GATE_DEFINES_SVH
`define LOCKED_EEPROM_ACCESS_GATE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset
`define LEG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed: implication");
// Next-cycle implication, checked out of reset
`define LEG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed: next-cycle implication");
`else
`define LEG_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LEG_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/leg_pkg.sv
// ----------------------------------------------------------------------------
// leg_pkg
// Shared constants, status codes and interface structs of the locked store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package leg_pkg;

    // Store geometry
    localparam int STORE_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CLR_W       = ADDR_W + 1;
    localparam int DATA_W      = 8;
    localparam int LIMIT_W     = 13;

    // Page decode and unlock sequence
    localparam logic [7:0]  WINDOW_PAGE   = 8'hFF;
    localparam logic [7:0]  DIRECT_PAGE   = 8'h00;
    localparam logic [15:0] WINDOW_OFFSET = 16'h1800;
    localparam logic [15:0] UNLOCK_ADDR   = 16'h1FFF;
    localparam logic [7:0]  CODE_FIRST    = 8'h55;
    localparam logic [7:0]  CODE_SECOND   = 8'hAA;
    localparam logic [7:0]  CODE_THIRD    = 8'h5A;
    localparam logic [7:0]  ERASED_BYTE   = 8'hFF;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'h0102;

    // Result status codes
    typedef enum logic [2:0] {
        ST_READ_OK   = 3'd0,
        ST_READ_REJ  = 3'd1,
        ST_WRITTEN   = 3'd2,
        ST_WRITE_REJ = 3'd3,
        ST_LOCKED    = 3'd4,
        ST_PROTECTED = 3'd5,
        ST_UNLOCK    = 3'd6
    } status_t;

    // One bus access
    typedef struct packed {
        logic        is_write;
        logic [7:0]  page;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic        protect_pin;
    } req_t;

    // Decoded access: status and store operation
    typedef struct packed {
        status_t             status;
        logic                rd_en;
        logic                wr_en;
        logic [ADDR_W-1:0]   addr;
        logic [DATA_W-1:0]   wdata;
    } dec_t;

endpackage

`default_nettype wire

FILE: rtl/leg_ram.sv
// ----------------------------------------------------------------------------
// leg_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module leg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write or read one entry per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/leg_clear.sv
// ----------------------------------------------------------------------------
// leg_clear
// Erase sweep after reset: writes the erased byte to every store entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module leg_clear
    import leg_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    output logic                   busy,
    output logic [ADDR_W-1:0]      addr
);

    logic [CLR_W-1:0] cnt_reg;
    logic [CLR_W-1:0] cnt_next;

    assign busy = (cnt_reg != CLR_W'(STORE_DEPTH));
    assign addr = cnt_reg[ADDR_W-1:0];

    // Advance one entry a cycle until the whole store is erased
    always_comb
    begin
        cnt_next = cnt_reg;
        if (busy)
        begin
            cnt_next = cnt_reg + CLR_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/leg_access.sv
// ----------------------------------------------------------------------------
// leg_access
// Access decode, unlock sequence and write-protect limit register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "locked_eeprom_access_gate_defines.svh"

module leg_access
    import leg_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [LIMIT_W-1:0] cfg_wdata,
    input  wire logic               acc,
    input  wire req_t               req,
    output dec_t                    dec
);

    typedef enum logic [1:0] {
        STAGE_FIRST    = 2'd0,
        STAGE_SECOND   = 2'd1,
        STAGE_THIRD    = 2'd2,
        STAGE_UNLOCKED = 2'd3
    } stage_t;

    stage_t              stage_reg;
    stage_t              stage_next;
    logic [LIMIT_W-1:0]  limit_reg;
    logic [LIMIT_W-1:0]  limit_next;

    logic                is_unlock;
    logic                is_window;
    logic                page_ok;
    logic [15:0]         eff_addr;
    logic                in_range;
    logic                below_limit;

    // Decode page, remap the window and check the range
    assign is_window   = (req.page == WINDOW_PAGE);
    assign is_unlock   = req.is_write && is_window && (req.address == UNLOCK_ADDR);
    assign page_ok     = is_window || (req.page == DIRECT_PAGE);
    assign eff_addr    = is_window ? (req.address - WINDOW_OFFSET) : req.address;
    assign in_range    = ({1'b0, eff_addr} < 17'(STORE_DEPTH));
    assign below_limit = (eff_addr < {3'b000, limit_reg});

    // Pick the status, the store operation and the next unlock stage
    always_comb
    begin
        dec.status = ST_READ_REJ;
        dec.rd_en  = 1'b0;
        dec.wr_en  = 1'b0;
        dec.addr   = eff_addr[ADDR_W-1:0];
        dec.wdata  = req.write_data;
        stage_next = stage_reg;
        if (is_unlock)
        begin
            dec.status = ST_UNLOCK;
            case (stage_reg)
                STAGE_FIRST:
                    stage_next = (req.write_data == CODE_FIRST)  ? STAGE_SECOND   : STAGE_FIRST;
                STAGE_SECOND:
                    stage_next = (req.write_data == CODE_SECOND) ? STAGE_THIRD    : STAGE_FIRST;
                STAGE_THIRD:
                    stage_next = (req.write_data == CODE_THIRD)  ? STAGE_UNLOCKED : STAGE_FIRST;
                default:
                    stage_next = (req.write_data == CODE_THIRD)  ? STAGE_UNLOCKED : STAGE_FIRST;
            endcase
        end
        else if (!page_ok || !in_range)
        begin
            dec.status = req.is_write ? ST_WRITE_REJ : ST_READ_REJ;
        end
        else if (!req.is_write)
        begin
            dec.status = ST_READ_OK;
            dec.rd_en  = 1'b1;
        end
        else if (stage_reg != STAGE_UNLOCKED)
        begin
            dec.status = ST_LOCKED;
            stage_next = STAGE_FIRST;
        end
        else if (below_limit && !req.protect_pin)
        begin
            dec.status = ST_PROTECTED;
        end
        else
        begin
            dec.status = ST_WRITTEN;
            dec.wr_en  = 1'b1;
        end
    end

    // Hold the limit unless written
    assign limit_next = cfg_we ? cfg_wdata : limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= STAGE_FIRST;
            limit_reg <= LIMIT_RESET;
        end
        else
        begin
            if (acc)
            begin
                stage_reg <= stage_next;
            end
            limit_reg <= limit_next;
        end
    end

    `LEG_ASSERT_IMP(a_write_needs_unlock, clk, rst_n, acc && dec.wr_en, stage_reg == STAGE_UNLOCKED)
    `LEG_ASSERT_NXT(a_locked_drop_relocks, clk, rst_n, acc && (dec.status == ST_LOCKED), stage_reg == STAGE_FIRST)

endmodule

`default_nettype wire

FILE: rtl/locked_eeprom_access_gate.sv
// ----------------------------------------------------------------------------
// locked_eeprom_access_gate
// Locked byte store with page remap, unlock sequence and write protection.
// ----------------------------------------------------------------------------
// Usage:
//   Each item on the s_ side is one bus access (read or write); each item
//   gives exactly one result item on the m_ side with the read byte and a
//   status code. Config: cfg_we/cfg_wdata write protect_limit while idle.
//   Path: a result goes through the store's registered read and the pending
//   stage, then the output register. Throughput: one item per cycle while
//   m_tready is high; the single store port takes at most one read or write
//   per item, and the unlock stage is updated in the accept cycle.
//   Reset: the store is erased to 0xFF by a sweep over all STORE_DEPTH (4096)
//   entries, one entry per cycle; s_tready stays low until it finishes.
//   The stage returns to locked and protect_limit to 0x0102.
//   Stall: when m_tready is low one more item is taken into the pending
//   stage, after which s_tready drops until the output drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "locked_eeprom_access_gate_defines.svh"

module locked_eeprom_access_gate
    import leg_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [LIMIT_W-1:0] cfg_wdata,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [39:0]        s_tdata,   // page[7:0], address[23:8],
                                               // write_data[31:24], protect_pin[32]
    input  wire logic               s_tuser,   // operation[0]
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [7:0]              m_tdata,   // read_data[7:0]
    output logic [2:0]              m_tuser    // status[2:0]
);

    req_t               req;
    dec_t               dec;
    logic               acc;
    logic               clr_busy;
    logic [ADDR_W-1:0]  clr_addr;
    logic               ram_we;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_addr;
    logic [DATA_W-1:0]  ram_wdata;
    logic [DATA_W-1:0]  ram_rdata;
    logic               pend_move;

    logic               pend_valid_reg;
    logic               pend_valid_next;
    status_t            pend_status_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [DATA_W-1:0]  out_data_reg;
    status_t            out_status_reg;

    // Unpack the input item
    assign req.is_write    = s_tuser;
    assign req.page        = s_tdata[7:0];
    assign req.address     = s_tdata[23:8];
    assign req.write_data  = s_tdata[31:24];
    assign req.protect_pin = s_tdata[32];

    // Accept while not erasing and the pending stage is free or draining
    assign pend_move = pend_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !clr_busy && (!pend_valid_reg || pend_move);
    assign acc       = s_tvalid && s_tready;

    leg_clear u_clear (
        .clk   (clk),
        .rst_n (rst_n),
        .busy  (clr_busy),
        .addr  (clr_addr)
    );

    leg_access u_access (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .acc       (acc),
        .req       (req),
        .dec       (dec)
    );

    // Share the store port between the erase sweep and accesses
    assign ram_we    = clr_busy || (acc && dec.wr_en);
    assign ram_re    = acc && dec.rd_en;
    assign ram_addr  = clr_busy ? clr_addr : dec.addr;
    assign ram_wdata = clr_busy ? ERASED_BYTE : dec.wdata;

    leg_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Pending stage waits for the read data, output register holds the result
    assign pend_valid_next = acc || (pend_valid_reg && !pend_move);
    assign out_valid_next  = pend_move || (out_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            pend_status_reg <= dec.status;
        end
        if (pend_move)
        begin
            out_status_reg <= pend_status_reg;
            out_data_reg   <= (pend_status_reg == ST_READ_OK) ? ram_rdata : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;

    `LEG_ASSERT_IMP(a_no_accept_while_erasing, clk, rst_n, clr_busy, !s_tready)
    `LEG_ASSERT_NXT(a_accept_fills_pending, clk, rst_n, acc, pend_valid_reg)
    `LEG_ASSERT_IMP(a_data_zero_unless_read, clk, rst_n, m_tvalid && (m_tuser != ST_READ_OK), m_tdata == '0)
    `LEG_ASSERT_IMP(a_single_port_use, clk, rst_n, ram_re, !ram_we)

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the locked byte store. Bus accesses go in on the
// s_ stream; a shadow of the store, the unlock stage and protect_limit
// predicts each result item, which is checked on the m_ stream in order.
// Covers page decode and remap, the unlock sequence, locked and protected
// writes, several protect_limit settings, random traffic and output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import leg_pkg::*;

    // Bus operation codes (s_tuser)
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam int STALL_MAX = 3;

    typedef enum logic [1:0] {
        STAGE_WANT_FIRST  = 2'd0,
        STAGE_WANT_SECOND = 2'd1,
        STAGE_WANT_THIRD  = 2'd2,
        STAGE_OPEN        = 2'd3
    } unlock_stage_t;

    typedef struct packed {
        logic [7:0] data;
        status_t    status;
    } reply_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [LIMIT_W-1:0] cfg_wdata;
    logic               s_tvalid;
    logic               s_tready;
    logic [39:0]        s_tdata;   // page[7:0], address[23:8],
                                   // write_data[31:24], protect_pin[32]
    logic               s_tuser;   // operation[0]
    logic               m_tvalid;
    logic               m_tready;
    logic [7:0]         m_tdata;   // read_data[7:0]
    logic [2:0]         m_tuser;   // status[2:0]

    // Shadow state of the block
    logic [DATA_W-1:0]  shadow_store [STORE_DEPTH];
    unlock_stage_t      shadow_stage;
    logic [LIMIT_W-1:0] shadow_limit;

    reply_t expected_replies[$];

    bit sender_idles = 1'b1;
    bit sink_idles   = 1'b1;
    int sink_hold    = 0;

    int accesses_sent  = 0;
    int replies_seen   = 0;
    int mismatch_count = 0;
    int limits_written = 0;
    int status_seen [7];

    locked_eeprom_access_gate DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // 10 ns clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Work out the result of one access and advance the shadow state
    function automatic reply_t predict_reply(input req_t acc);
        reply_t      r;
        logic [15:0] loc;
        bit          page_ok;
        r.data   = '0;
        r.status = ST_UNLOCK;
        // Unlock register: never reaches the store
        if (acc.is_write == OP_WRITE && acc.page == WINDOW_PAGE
            && acc.address == UNLOCK_ADDR)
        begin
            case (shadow_stage)
                STAGE_WANT_FIRST:
                    shadow_stage = (acc.write_data == CODE_FIRST) ?
                                   STAGE_WANT_SECOND : STAGE_WANT_FIRST;
                STAGE_WANT_SECOND:
                    shadow_stage = (acc.write_data == CODE_SECOND) ?
                                   STAGE_WANT_THIRD : STAGE_WANT_FIRST;
                default:
                    shadow_stage = (acc.write_data == CODE_THIRD) ?
                                   STAGE_OPEN : STAGE_WANT_FIRST;
            endcase
            return r;
        end
        // Page decode, window remapped with 16-bit wrap
        loc     = acc.address;
        page_ok = (acc.page == DIRECT_PAGE);
        if (acc.page == WINDOW_PAGE)
        begin
            page_ok = 1'b1;
            loc     = acc.address - WINDOW_OFFSET;
        end
        if (!page_ok || loc >= STORE_DEPTH)
            r.status = (acc.is_write == OP_WRITE) ? ST_WRITE_REJ : ST_READ_REJ;
        else if (acc.is_write == OP_READ)
        begin
            r.data   = shadow_store[loc[ADDR_W-1:0]];
            r.status = ST_READ_OK;
        end
        else if (shadow_stage != STAGE_OPEN)
        begin
            shadow_stage = STAGE_WANT_FIRST;
            r.status     = ST_LOCKED;
        end
        else if (loc < shadow_limit && !acc.protect_pin)
            r.status = ST_PROTECTED;
        else
        begin
            shadow_store[loc[ADDR_W-1:0]] = acc.write_data;
            r.status = ST_WRITTEN;
        end
        return r;
    endfunction

    // Predict on every accepted item, check every result item
    always @(posedge clk)
    begin : watch_bus
        req_t   acc;
        reply_t want;
        if (rst_n && s_tvalid && s_tready)
        begin
            acc.is_write    = s_tuser;
            acc.page        = s_tdata[7:0];
            acc.address     = s_tdata[23:8];
            acc.write_data  = s_tdata[31:24];
            acc.protect_pin = s_tdata[32];
            expected_replies.push_back(predict_reply(acc));
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            replies_seen++;
            if (m_tuser < 3'd7)
                status_seen[m_tuser]++;
            if (expected_replies.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result item, data %02h status %0d",
                         $time, m_tdata, m_tuser);
            end
            else
            begin
                want = expected_replies.pop_front();
                if (m_tuser !== want.status)
                begin
                    mismatch_count++;
                    $display("%0t: status mismatch, expected %0d (%s), actual %0d",
                             $time, want.status, want.status.name(), m_tuser);
                end
                if (m_tdata !== want.data)
                begin
                    mismatch_count++;
                    $display("%0t: read_data mismatch, expected %02h, actual %02h",
                             $time, want.data, m_tdata);
                end
            end
        end
    end

    // Result side: random stalls per item, or a long hold when asked
    initial
    begin : sink
        int stall;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (sink_hold > 0)
            begin
                stall     = sink_hold;
                sink_hold = 0;
            end
            else
                stall = sink_idles ? $urandom_range(0, STALL_MAX) : 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    function automatic req_t make_access(input logic op, input logic [7:0] page,
                                         input logic [15:0] addr,
                                         input logic [7:0] data, input logic pin);
        req_t acc;
        acc.is_write    = op;
        acc.page        = page;
        acc.address     = addr;
        acc.write_data  = data;
        acc.protect_pin = pin;
        return acc;
    endfunction

    // Offer one item after a random gap and hold it until accepted
    task automatic send_access(input req_t acc);
        int gap;
        gap = sender_idles ? $urandom_range(0, STALL_MAX) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, acc.protect_pin, acc.write_data, acc.address, acc.page};
        s_tuser  <= acc.is_write;
        accesses_sent++;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic send_code(input logic [7:0] code);
        send_access(make_access(OP_WRITE, WINDOW_PAGE, UNLOCK_ADDR, code,
                                1'($urandom_range(0, 1))));
    endtask

    task automatic open_store();
        send_code(CODE_FIRST);
        send_code(CODE_SECOND);
        send_code(CODE_THIRD);
    endtask

    // In-range access through either the direct page or the window
    task automatic send_store_access(input logic op, input logic [15:0] loc,
                                     input logic [7:0] data, input logic pin);
        if ($urandom_range(0, 1))
            send_access(make_access(op, WINDOW_PAGE, loc + WINDOW_OFFSET, data, pin));
        else
            send_access(make_access(op, DIRECT_PAGE, loc, data, pin));
    endtask

    // Store address biased to the low end, the top end and the limit boundary
    function automatic logic [15:0] pick_store_addr();
        int lo;
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 31));
            1:
            begin
                lo = int'(shadow_limit) - 4;
                if (lo < 0)
                    lo = 0;
                if (lo > STORE_DEPTH - 9)
                    lo = STORE_DEPTH - 9;
                return 16'(lo + $urandom_range(0, 8));
            end
            2: return 16'($urandom_range(0, STORE_DEPTH - 1));
            default: return 16'($urandom_range(STORE_DEPTH - 32, STORE_DEPTH - 1));
        endcase
    endfunction

    function automatic req_t random_access();
        logic [7:0] page;
        case ($urandom_range(0, 3))
            0: page = DIRECT_PAGE;
            1: page = WINDOW_PAGE;
            default: page = 8'($urandom_range(0, 255));
        endcase
        return make_access(1'($urandom_range(0, 1)), page,
                           16'($urandom_range(0, 65535)),
                           8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endfunction

    // Drop valid and let every outstanding result item arrive
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_protect_limit(input logic [LIMIT_W-1:0] value);
        wait_drained();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        shadow_limit = value;
        limits_written++;
    endtask

    // Mostly unlock-then-access sequences, some broken ones and some noise
    task automatic run_mixed_traffic(input int count);
        int         target;
        int         pick;
        int         steps;
        logic [7:0] codes [3];
        codes  = '{CODE_FIRST, CODE_SECOND, CODE_THIRD};
        target = accesses_sent + count;
        while (accesses_sent < target)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
            begin
                open_store();
                if ($urandom_range(0, 3) == 0)
                    send_code(CODE_THIRD);
                repeat ($urandom_range(4, 12))
                    send_store_access(($urandom_range(0, 9) < 6) ? OP_WRITE : OP_READ,
                                      pick_store_addr(), 8'($urandom_range(0, 255)),
                                      1'($urandom_range(0, 1)));
                if ($urandom_range(0, 1))
                    send_code(8'($urandom_range(0, 255)));
            end
            else if (pick < 8)
            begin
                steps = $urandom_range(0, 2);
                for (int i = 0; i < steps; i++)
                    send_code(codes[i]);
                send_code(8'($urandom_range(0, 255)));
                send_store_access(OP_WRITE, pick_store_addr(),
                                  8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
            else
                repeat ($urandom_range(1, 4))
                    send_access(random_access());
        end
    endtask

    // Decode edges, unlock sequence and the locked, protected and relock cases
    task automatic test_decode_and_unlock();
        send_access(make_access(OP_READ,  DIRECT_PAGE, 16'h0000, 8'h00, 1'b0));
        send_access(make_access(OP_READ,  DIRECT_PAGE, 16'h0FFF, 8'h00, 1'b1));
        send_access(make_access(OP_READ,  DIRECT_PAGE, 16'h1000, 8'h00, 1'b0));
        send_access(make_access(OP_READ,  DIRECT_PAGE, 16'hFFFF, 8'hFF, 1'b1));
        send_access(make_access(OP_READ,  WINDOW_PAGE, 16'h1800, 8'h00, 1'b0));
        send_access(make_access(OP_READ,  WINDOW_PAGE, UNLOCK_ADDR, 8'h00, 1'b0));
        send_access(make_access(OP_READ,  WINDOW_PAGE, 16'h17FF, 8'h00, 1'b0));
        send_access(make_access(OP_READ,  WINDOW_PAGE, 16'h27FF, 8'h00, 1'b0));
        send_access(make_access(OP_READ,  8'h01,       16'h0000, 8'h00, 1'b0));
        send_access(make_access(OP_WRITE, 8'hFE,       UNLOCK_ADDR, CODE_FIRST, 1'b1));
        // Locked write
        send_access(make_access(OP_WRITE, DIRECT_PAGE, 16'h0200, 8'h11, 1'b1));
        // Unlock with rejected accesses in between, which keep the stage
        send_code(CODE_FIRST);
        send_access(make_access(OP_WRITE, DIRECT_PAGE, 16'h1000, 8'h22, 1'b1));
        send_code(CODE_SECOND);
        send_access(make_access(OP_WRITE, 8'h80,       16'h0000, 8'h33, 1'b1));
        send_code(CODE_THIRD);
        send_code(CODE_THIRD);
        // Writes around the reset protect limit
        send_access(make_access(OP_WRITE, DIRECT_PAGE, 16'h0300, 8'hA5, 1'b0));
        send_access(make_access(OP_WRITE, WINDOW_PAGE, 16'h1901, 8'h3C, 1'b0));
        send_access(make_access(OP_WRITE, DIRECT_PAGE, 16'h0101, 8'h3C, 1'b1));
        send_access(make_access(OP_WRITE, DIRECT_PAGE, 16'h0102, 8'hC3, 1'b0));
        send_access(make_access(OP_READ,  WINDOW_PAGE, 16'h1B00, 8'h00, 1'b0));
        send_access(make_access(OP_READ,  DIRECT_PAGE, 16'h0101, 8'h00, 1'b0));
        send_access(make_access(OP_WRITE, DIRECT_PAGE, UNLOCK_ADDR, 8'h5A, 1'b1));
        // Wrong byte relocks; a locked write restarts the sequence
        send_code(8'h00);
        send_access(make_access(OP_WRITE, DIRECT_PAGE, 16'h0004, 8'h44, 1'b1));
        send_code(CODE_FIRST);
        send_access(make_access(OP_WRITE, DIRECT_PAGE, 16'h0005, 8'h55, 1'b1));
        send_code(CODE_SECOND);
    endtask

    // Boundary writes under the extreme limits, their neighbours and a random middle limit
    task automatic test_protect_limits();
        logic [LIMIT_W-1:0] limits [5];
        logic [15:0]        edge_lo;
        logic [15:0]        edge_hi;
        limits = '{13'd0, 13'(STORE_DEPTH), 13'd1, 13'(STORE_DEPTH - 1),
                   13'($urandom_range(2, STORE_DEPTH - 2))};
        foreach (limits[i])
        begin
            set_protect_limit(limits[i]);
            edge_hi = 16'(limits[i]);
            edge_lo = edge_hi - 16'd1;
            open_store();
            send_access(make_access(OP_WRITE, DIRECT_PAGE, edge_lo, 8'h96, 1'b0));
            send_access(make_access(OP_WRITE, DIRECT_PAGE, edge_hi, 8'h69, 1'b0));
            send_store_access(OP_READ, edge_lo, 8'h00, 1'b0);
            send_store_access(OP_WRITE, edge_lo, 8'h0F, 1'b1);
            send_store_access(OP_READ, edge_lo, 8'h00, 1'b1);
            send_store_access(OP_READ, edge_hi, 8'h00, 1'b0);
            send_code(8'hF0);
        end
    endtask

    task automatic test_random_traffic();
        set_protect_limit(LIMIT_RESET);
        run_mixed_traffic(500);
        set_protect_limit(13'(STORE_DEPTH));
        run_mixed_traffic(350);
        set_protect_limit(13'd0);
        run_mixed_traffic(350);
        set_protect_limit(13'($urandom_range(1, STORE_DEPTH - 1)));
        run_mixed_traffic(400);
    endtask

    // Hold the result side for a long stretch while items keep coming
    task automatic test_output_stall();
        wait_drained();
        sender_idles = 1'b0;
        sink_hold    = 300;
        open_store();
        repeat (40)
            send_store_access(($urandom_range(0, 1)) ? OP_WRITE : OP_READ,
                              pick_store_addr(), 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
        wait_drained();
        sender_idles = 1'b1;
    endtask

    // Full rate on both sides
    task automatic test_back_to_back();
        sender_idles = 1'b0;
        sink_idles   = 1'b0;
        run_mixed_traffic(250);
        sender_idles = 1'b1;
        sink_idles   = 1'b1;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_READ;
        m_tready  = 1'b0;
        foreach (shadow_store[i])
            shadow_store[i] = ERASED_BYTE;
        shadow_stage = STAGE_WANT_FIRST;
        shadow_limit = LIMIT_RESET;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        // Hold off until the erase sweep has finished
        do @(posedge clk); while (!s_tready);

        test_decode_and_unlock();
        test_protect_limits();
        test_random_traffic();
        test_output_stall();
        test_back_to_back();

        wait_drained();
        repeat (10) @(posedge clk);
        $display("Run covered %0d accesses, %0d result items, %0d protect_limit writes.",
                 accesses_sent, replies_seen, limits_written);
        $display({"Results: read ok %0d, read rej %0d, written %0d, write rej %0d, ",
                  "locked %0d, protected %0d, unlock %0d"},
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4], status_seen[5], status_seen[6]);
        if (mismatch_count == 0 && expected_replies.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #3_000_000;
        $display("%0t: timeout with %0d result items outstanding",
                 $time, expected_replies.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
